// File: src/gb3_pkg.sv
// Shared types and constants of the 3x3 Gaussian blur block.
package gb3_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int PIXEL_BITS      = 8;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    typedef struct packed {
        logic                  action;
        logic [PIXEL_BITS-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_pixel;
        logic [ROW_BITS-1:0]   out_row;
        logic [COL_BITS-1:0]   out_col;
        logic                  last_of_image;
    } out_item_t;

    // Up to two results enter the result queue in one cycle; item1 only with item0.
    typedef struct packed {
        logic      valid0;
        logic      valid1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

endpackage

// File: src/gb3_result_fifo.sv
// Result queue that takes up to two items per cycle and hands out one while out_ready is high.
module gb3_result_fifo import gb3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  push_t                    push,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_item,
    output logic [FIFO_CNT_BITS-1:0] count
);

    out_item_t                slot_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic [FIFO_CNT_BITS-1:0] count_next;
    logic [FIFO_CNT_BITS-1:0] push_n;
    logic                     pop;

    assign pop       = out_ready && (count_reg != '0);
    assign push_n    = FIFO_CNT_BITS'(push.valid0) + FIFO_CNT_BITS'(push.valid1);
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = FIFO_PTR_BITS'(wr_ptr_reg + push_n[FIFO_PTR_BITS-1:0]);
        rd_ptr_next = FIFO_PTR_BITS'(rd_ptr_reg + FIFO_PTR_BITS'(pop));
        count_next  = FIFO_CNT_BITS'(count_reg + push_n - FIFO_CNT_BITS'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            slot_mem[wr_ptr_reg] <= push.item0;
        end
        if (push.valid1)
        begin
            slot_mem[FIFO_PTR_BITS'(wr_ptr_reg + 1'b1)] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/gaussian_blur_3x3_clamped_top.sv
// Results of an accepted item are formed in the second stage and queued in the result queue.
// Throughput: one item per cycle while in_ready is high; line stores are read every cycle.
// After an image's last pixel, input is held off while column 0 is fetched for the flush.
// Row ends after row 0 give up to two results in one cycle; in_ready drops near a full queue.
// Reset (asynchronous, active low) clears counters, window and queue, and sets 1024 x 4096;
// the line stores are not cleared.
module gaussian_blur_3x3_clamped_top import gb3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_item,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int VSUM_BITS = PIXEL_BITS + 2;
    localparam int HSUM_BITS = PIXEL_BITS + 4;

    typedef enum logic [1:0] {OP_NONE, OP_PIXEL, OP_FLUSH, OP_PREFETCH} op_t;

    function automatic logic [VSUM_BITS-1:0] col_sum(input logic [PIXEL_BITS-1:0] top,
                                                     input logic [PIXEL_BITS-1:0] mid,
                                                     input logic [PIXEL_BITS-1:0] bot);
        col_sum = VSUM_BITS'(top) + (VSUM_BITS'(mid) << 1) + VSUM_BITS'(bot);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] blur(input logic [VSUM_BITS-1:0] l,
                                                   input logic [VSUM_BITS-1:0] m,
                                                   input logic [VSUM_BITS-1:0] r);
        logic [HSUM_BITS-1:0] s;
        s    = HSUM_BITS'(l) + (HSUM_BITS'(m) << 1) + HSUM_BITS'(r);
        blur = s[HSUM_BITS-1:4];
    endfunction

    // Configuration values are held as last index; zero acts as one, oversize as the maximum.
    function automatic logic [COL_BITS-1:0] width_last(input logic [WIDTH_REG_BITS-1:0] v);
        if (v == '0)
            width_last = '0;
        else if (v > WIDTH_REG_BITS'(MAX_WIDTH))
            width_last = COL_BITS'(MAX_WIDTH - 1);
        else
            width_last = COL_BITS'(v - 1'b1);
    endfunction

    function automatic logic [ROW_BITS-1:0] height_last(input logic [HEIGHT_REG_BITS-1:0] v);
        if (v == '0)
            height_last = '0;
        else if (v > HEIGHT_REG_BITS'(MAX_HEIGHT))
            height_last = ROW_BITS'(MAX_HEIGHT - 1);
        else
            height_last = ROW_BITS'(v - 1'b1);
    endfunction

    // Configuration and stream position
    logic [COL_BITS-1:0] w_last_reg;
    logic [ROW_BITS-1:0] h_last_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] flush_col_reg;
    logic                done_reg;
    logic                pf_pending_reg;

    // Line stores
    logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] older_rd_reg;
    logic [PIXEL_BITS-1:0] newer_rd_reg;

    // Second stage
    op_t                   b_op_reg;
    logic [COL_BITS-1:0]   b_col_reg;
    logic [ROW_BITS-1:0]   b_row_reg;
    logic [PIXEL_BITS-1:0] b_pixel_reg;
    logic                  b_fwd_hit_reg;
    logic [PIXEL_BITS-1:0] b_fwd_data_reg;

    // Column sums of the window and of the flush row
    logic [VSUM_BITS-1:0] win1_reg;
    logic [VSUM_BITS-1:0] win2_reg;
    logic [VSUM_BITS-1:0] fl_left_reg;
    logic [VSUM_BITS-1:0] fl_mid_reg;

    // First stage signals
    logic                accept;
    logic                a_pixel;
    logic                a_flush;
    op_t                 a_op;
    logic [COL_BITS-1:0] a_addr;
    logic                fwd_hit_next;

    // Second stage signals
    logic                  b_writes_older;
    logic [PIXEL_BITS-1:0] mid_val;
    logic [PIXEL_BITS-1:0] older_val;
    logic [PIXEL_BITS-1:0] pix_top;
    logic [PIXEL_BITS-1:0] fl_top;
    logic [VSUM_BITS-1:0]  vs_pix;
    logic [VSUM_BITS-1:0]  vs_fl;
    logic [VSUM_BITS-1:0]  w0;
    logic [VSUM_BITS-1:0]  w1;
    logic                  emit_centre;
    logic                  emit_edge;
    out_item_t             res_centre;
    out_item_t             res_edge;
    out_item_t             res_flush;
    push_t                 push;

    logic [FIFO_CNT_BITS-1:0] fifo_count;
    logic [FIFO_CNT_BITS:0]   reserve;

    // Room for two results of the held item and two of a new one.
    assign reserve  = (FIFO_CNT_BITS + 1)'(fifo_count)
                    + ((b_op_reg != OP_NONE) ? (FIFO_CNT_BITS + 1)'(2) : '0);
    assign in_ready = !pf_pending_reg && (reserve <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH - 2));

    assign accept  = in_valid && in_ready;
    assign a_pixel = accept && !in_item.action && !done_reg;
    assign a_flush = accept && in_item.action && done_reg;

    always_comb
    begin
        priority if (pf_pending_reg)
        begin
            a_op   = OP_PREFETCH;
            a_addr = '0;
        end
        else if (a_pixel)
        begin
            a_op   = OP_PIXEL;
            a_addr = col_reg;
        end
        else if (a_flush)
        begin
            a_op   = OP_FLUSH;
            a_addr = (flush_col_reg == w_last_reg) ? flush_col_reg
                                                   : COL_BITS'(flush_col_reg + 1'b1);
        end
        else
        begin
            a_op   = OP_NONE;
            a_addr = col_reg;
        end
    end

    // The older store is written in the cycle after its read; a read of the same entry
    // in that cycle takes the value being written instead.
    assign b_writes_older = (b_op_reg == OP_PIXEL) && (b_row_reg != '0);
    assign fwd_hit_next   = b_writes_older && (b_col_reg == a_addr);

    always_ff @(posedge clk)
    begin
        newer_rd_reg <= newer_mem[a_addr];
        if (a_op == OP_PIXEL)
        begin
            newer_mem[a_addr] <= in_item.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        older_rd_reg <= older_mem[a_addr];
        if (b_writes_older)
        begin
            older_mem[b_col_reg] <= newer_rd_reg;
        end
    end

    always_comb
    begin
        mid_val   = newer_rd_reg;
        older_val = b_fwd_hit_reg ? b_fwd_data_reg : older_rd_reg;
        pix_top   = (b_row_reg == ROW_BITS'(1)) ? mid_val : older_val;
        fl_top    = (h_last_reg == '0) ? mid_val : older_val;
        vs_pix    = col_sum(pix_top, mid_val, b_pixel_reg);
        vs_fl     = col_sum(fl_top, mid_val, mid_val);
        w0        = (b_col_reg == '0) ? vs_pix : win1_reg;
        w1        = (b_col_reg == '0) ? vs_pix : win2_reg;

        emit_centre = b_writes_older && (b_col_reg != '0);
        emit_edge   = b_writes_older && (b_col_reg == w_last_reg);

        res_centre.out_pixel     = blur(w0, w1, vs_pix);
        res_centre.out_row       = ROW_BITS'(b_row_reg - 1'b1);
        res_centre.out_col       = COL_BITS'(b_col_reg - 1'b1);
        res_centre.last_of_image = 1'b0;

        res_edge.out_pixel     = blur(w1, vs_pix, vs_pix);
        res_edge.out_row       = ROW_BITS'(b_row_reg - 1'b1);
        res_edge.out_col       = b_col_reg;
        res_edge.last_of_image = 1'b0;

        res_flush.out_pixel     = blur(fl_left_reg, fl_mid_reg, vs_fl);
        res_flush.out_row       = h_last_reg;
        res_flush.out_col       = b_col_reg;
        res_flush.last_of_image = (b_col_reg == w_last_reg);

        push.valid0 = 1'b0;
        push.valid1 = 1'b0;
        push.item0  = res_centre;
        push.item1  = res_edge;
        unique case (b_op_reg)
            OP_PIXEL:
            begin
                if (emit_centre)
                begin
                    push.valid0 = 1'b1;
                    push.valid1 = emit_edge;
                end
                else
                begin
                    push.valid0 = emit_edge;
                    push.item0  = res_edge;
                end
            end
            OP_FLUSH:
            begin
                push.valid0 = 1'b1;
                push.item0  = res_flush;
            end
            default:
            begin
                push.valid0 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        b_col_reg      <= (a_op == OP_FLUSH) ? flush_col_reg : a_addr;
        b_row_reg      <= row_reg;
        b_pixel_reg    <= in_item.pixel;
        b_fwd_data_reg <= newer_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg     <= COL_BITS'(MAX_WIDTH - 1);
            h_last_reg     <= ROW_BITS'(MAX_HEIGHT - 1);
            row_reg        <= '0;
            col_reg        <= '0;
            flush_col_reg  <= '0;
            done_reg       <= 1'b0;
            pf_pending_reg <= 1'b0;
            b_op_reg       <= OP_NONE;
            b_fwd_hit_reg  <= 1'b0;
            win1_reg       <= '0;
            win2_reg       <= '0;
            fl_left_reg    <= '0;
            fl_mid_reg     <= '0;
        end
        else
        begin
            b_op_reg      <= a_op;
            b_fwd_hit_reg <= fwd_hit_next;

            if (b_writes_older)
            begin
                win1_reg <= w1;
                win2_reg <= vs_pix;
            end
            if (b_op_reg == OP_PREFETCH)
            begin
                fl_left_reg <= vs_fl;
                fl_mid_reg  <= vs_fl;
            end
            else if (b_op_reg == OP_FLUSH)
            begin
                fl_left_reg <= fl_mid_reg;
                fl_mid_reg  <= vs_fl;
            end

            if (cfg_write_en)
            begin
                // Any register write restarts the stream.
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  w_last_reg <= width_last(cfg_data[WIDTH_REG_BITS-1:0]);
                    REG_IMAGE_HEIGHT: h_last_reg <= height_last(cfg_data);
                    default:          w_last_reg <= w_last_reg;
                endcase
                row_reg        <= '0;
                col_reg        <= '0;
                flush_col_reg  <= '0;
                done_reg       <= 1'b0;
                pf_pending_reg <= 1'b0;
            end
            else
            begin
                pf_pending_reg <= 1'b0;
                if (a_pixel)
                begin
                    if (col_reg == w_last_reg)
                    begin
                        col_reg <= '0;
                        if (row_reg == h_last_reg)
                        begin
                            done_reg       <= 1'b1;
                            flush_col_reg  <= '0;
                            pf_pending_reg <= 1'b1;
                        end
                        else
                        begin
                            row_reg <= ROW_BITS'(row_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        col_reg <= COL_BITS'(col_reg + 1'b1);
                    end
                end
                else if (a_flush)
                begin
                    if (flush_col_reg == w_last_reg)
                    begin
                        row_reg       <= '0;
                        col_reg       <= '0;
                        flush_col_reg <= '0;
                        done_reg      <= 1'b0;
                    end
                    else
                    begin
                        flush_col_reg <= COL_BITS'(flush_col_reg + 1'b1);
                    end
                end
            end
        end
    end

    gb3_result_fifo u_result_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .count     (fifo_count)
    );

endmodule
